/* hw/rtl/text_binary_sniffer_macros.svh */
// ----------------------------------------------------------------------------
// text_binary_sniffer assertion macros
// shared property shorthands for the sniffer's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TEXT_BINARY_SNIFFER_MACROS_SVH
`define TEXT_BINARY_SNIFFER_MACROS_SVH

// same-cycle implication
`define TBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text_binary_sniffer check failed");

// next-cycle implication
`define TBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_binary_sniffer check failed");

`endif

/* hw/rtl/tbs_pkg.sv */
// ----------------------------------------------------------------------------
// tbs_pkg
// types and constants shared by the text/binary sniffer modules
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PCT_W      = 7;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;

  typedef enum logic [2:0] {
    REASON_EMPTY  = 3'd0,
    REASON_MARK   = 3'd1,
    REASON_NUL    = 3'd2,
    REASON_C0     = 3'd3,
    REASON_UTF8   = 3'd4,
    REASON_LATIN1 = 3'd5,
    REASON_C1     = 3'd6
  } reason_t;

  typedef struct packed {
    logic empty;
    logic mark;
    logic nul;
    logic broken;
  } snap_flags_t;

  typedef struct packed {
    logic    looks_text;
    logic    utf8_clean;
    reason_t reason;
  } result_t;

endpackage

/* hw/rtl/tbs_accum.sv */
// ----------------------------------------------------------------------------
// tbs_accum
// per-byte counters, mark capture and utf-8 decoder state; snapshots the
// sample summary on the request that ends a sample
// ----------------------------------------------------------------------------
module tbs_accum
  import tbs_pkg::*;
#(
  parameter longint unsigned MAX_SAMPLE_BYTES = 65535,
  parameter int              CNT_W            = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             empty_sample,
  output logic             snap_valid,
  output logic [CNT_W-1:0] snap_bytes,
  output logic [CNT_W-1:0] snap_c0,
  output logic [CNT_W-1:0] snap_c1,
  output snap_flags_t      snap_flags
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLE_BYTES);

  typedef enum logic [2:0] {
    BND_PLAIN = 3'd0,
    BND_A0_BF = 3'd1,
    BND_80_9F = 3'd2,
    BND_90_BF = 3'd3,
    BND_80_8F = 3'd4
  } bound_t;

  logic [23:0]      lead_r, lead_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [CNT_W-1:0] c0_r, c0_nxt;
  logic [CNT_W-1:0] c1_r, c1_nxt;
  logic             nul_r, nul_nxt;
  logic [1:0]       owed_r, owed_nxt;
  bound_t           bnd_r, bnd_nxt;
  logic             broken_r, broken_nxt;

  logic             snap_valid_r;
  logic [CNT_W-1:0] snap_bytes_r, snap_c0_r, snap_c1_r;
  snap_flags_t      snap_flags_r, flags_nxt;

  logic             is_nul, is_c0, is_c1, ends;
  logic [7:0]       lo, hi;

  assign is_nul = (data_byte == 8'h00);
  assign is_c0  = !is_nul && (data_byte < 8'h20) && (data_byte != 8'h09) &&
                  (data_byte != 8'h0a) && (data_byte != 8'h0d) && (data_byte != 8'h0c);
  assign is_c1  = (data_byte >= 8'h80) && (data_byte <= 8'h9f);
  assign ends   = last_byte || empty_sample;

  always_comb begin
    lead_nxt   = lead_r;
    bc_nxt     = bc_r;
    c0_nxt     = c0_r;
    c1_nxt     = c1_r;
    nul_nxt    = nul_r;
    owed_nxt   = owed_r;
    bnd_nxt    = bnd_r;
    broken_nxt = broken_r;
    lo         = 8'h80;
    hi         = 8'hbf;
    unique case (bnd_r)
      BND_A0_BF: lo = 8'ha0;
      BND_80_9F: hi = 8'h9f;
      BND_90_BF: lo = 8'h90;
      BND_80_8F: hi = 8'h8f;
      default:   ;
    endcase
    if (!empty_sample) begin
      if (bc_r < CNT_W'(3)) begin
        case (bc_r[1:0])
          2'd0:    lead_nxt[7:0]   = data_byte;
          2'd1:    lead_nxt[15:8]  = data_byte;
          2'd2:    lead_nxt[23:16] = data_byte;
          default: ;
        endcase
      end
      bc_nxt = (bc_r == CNT_MAX) ? bc_r : bc_r + 1'b1;
      if (is_nul) begin
        nul_nxt = 1'b1;
      end else if (is_c0) begin
        c0_nxt = (c0_r == CNT_MAX) ? c0_r : c0_r + 1'b1;
      end else if (is_c1) begin
        c1_nxt = (c1_r == CNT_MAX) ? c1_r : c1_r + 1'b1;
      end
      if (!broken_r) begin
        if (owed_r != 2'd0) begin
          if (data_byte < lo || data_byte > hi) begin
            broken_nxt = 1'b1;
          end else begin
            owed_nxt = owed_r - 2'd1;
            bnd_nxt  = BND_PLAIN;
          end
        end else begin
          bnd_nxt = BND_PLAIN;
          if (data_byte < 8'h80) begin
            owed_nxt = 2'd0;
          end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
            owed_nxt = 2'd1;
          end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
            owed_nxt = 2'd2;
            if (data_byte == 8'he0) begin
              bnd_nxt = BND_A0_BF;
            end else if (data_byte == 8'hed) begin
              bnd_nxt = BND_80_9F;
            end
          end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
            owed_nxt = 2'd3;
            if (data_byte == 8'hf0) begin
              bnd_nxt = BND_90_BF;
            end else if (data_byte == 8'hf4) begin
              bnd_nxt = BND_80_8F;
            end
          end else begin
            broken_nxt = 1'b1;
          end
        end
      end
    end
    flags_nxt.empty  = (bc_nxt == '0);
    flags_nxt.mark   = ((bc_nxt >= CNT_W'(3)) && (lead_nxt == 24'hbfbbef)) ||
                       ((bc_nxt >= CNT_W'(2)) &&
                        ((lead_nxt[15:0] == 16'hfeff) || (lead_nxt[15:0] == 16'hfffe)));
    flags_nxt.nul    = nul_nxt;
    flags_nxt.broken = broken_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r       <= '0;
      bc_r         <= '0;
      c0_r         <= '0;
      c1_r         <= '0;
      nul_r        <= 1'b0;
      owed_r       <= 2'd0;
      bnd_r        <= BND_PLAIN;
      broken_r     <= 1'b0;
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= take && ends;
      if (take) begin
        if (ends) begin
          lead_r   <= '0;
          bc_r     <= '0;
          c0_r     <= '0;
          c1_r     <= '0;
          nul_r    <= 1'b0;
          owed_r   <= 2'd0;
          bnd_r    <= BND_PLAIN;
          broken_r <= 1'b0;
        end else begin
          lead_r   <= lead_nxt;
          bc_r     <= bc_nxt;
          c0_r     <= c0_nxt;
          c1_r     <= c1_nxt;
          nul_r    <= nul_nxt;
          owed_r   <= owed_nxt;
          bnd_r    <= bnd_nxt;
          broken_r <= broken_nxt;
        end
      end
    end
  end

  // summary payload
  always_ff @(posedge clk) begin
    if (take && ends) begin
      snap_bytes_r <= bc_nxt;
      snap_c0_r    <= c0_nxt;
      snap_c1_r    <= c1_nxt;
      snap_flags_r <= flags_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_bytes = snap_bytes_r;
  assign snap_c0    = snap_c0_r;
  assign snap_c1    = snap_c1_r;
  assign snap_flags = snap_flags_r;

endmodule

/* hw/rtl/tbs_verdict.sv */
// ----------------------------------------------------------------------------
// tbs_verdict
// scales the counts, compares the control shares and picks the verdict
// ----------------------------------------------------------------------------
module tbs_verdict
  import tbs_pkg::*;
#(
  parameter int CNT_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  input  logic [CNT_W-1:0] snap_bytes,
  input  logic [CNT_W-1:0] snap_c0,
  input  logic [CNT_W-1:0] snap_c1,
  input  snap_flags_t      snap_flags,
  input  logic [PCT_W-1:0] control_pct,
  output logic             res_valid,
  output result_t          res
);

  localparam int PW = CNT_W + PCT_W;

  logic          a_valid_r;
  logic [PW-1:0] tot_r, c0x_r, c1x_r;
  snap_flags_t   flags_r;
  logic [PW-1:0] c0_w, c1_w;
  logic          c0_over, c1_over;

  assign c0_w = PW'(snap_c0);
  assign c1_w = PW'(snap_c1);

  // count * 100 as shifts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid) begin
      tot_r   <= PW'(snap_bytes) * PW'(control_pct);
      c0x_r   <= (c0_w << 6) + (c0_w << 5) + (c0_w << 2);
      c1x_r   <= (c1_w << 6) + (c1_w << 5) + (c1_w << 2);
      flags_r <= snap_flags;
    end
  end

  assign c0_over = (c0x_r > tot_r);
  assign c1_over = (c1x_r > tot_r);

  always_comb begin
    res.utf8_clean = !flags_r.broken;
    if (flags_r.empty) begin
      res.looks_text = 1'b1;
      res.reason     = REASON_EMPTY;
    end else if (flags_r.mark) begin
      res.looks_text = 1'b1;
      res.reason     = REASON_MARK;
    end else if (flags_r.nul) begin
      res.looks_text = 1'b0;
      res.reason     = REASON_NUL;
    end else if (c0_over) begin
      res.looks_text = 1'b0;
      res.reason     = REASON_C0;
    end else if (!flags_r.broken) begin
      res.looks_text = 1'b1;
      res.reason     = REASON_UTF8;
    end else if (c1_over) begin
      res.looks_text = 1'b0;
      res.reason     = REASON_C1;
    end else begin
      res.looks_text = 1'b1;
      res.reason     = REASON_LATIN1;
    end
  end

  assign res_valid = a_valid_r;

endmodule

/* hw/rtl/tbs_fifo.sv */
// ----------------------------------------------------------------------------
// tbs_fifo
// small verdict queue between the verdict logic and the result channel
// ----------------------------------------------------------------------------
module tbs_fifo
  import tbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  result_t          push_data,
  input  logic             pop,
  output logic             not_empty,
  output result_t          head,
  output logic [OCC_W-1:0] count
);

  result_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

/* hw/rtl/text_binary_sniffer.sv */
// ----------------------------------------------------------------------------
// text_binary_sniffer
// text versus binary detection of a byte sample with strict utf-8 checking
// ----------------------------------------------------------------------------
// Takes one sample byte per cycle and gives one verdict per sample. The
// verdict for a sample shows on the result channel after the request that
// ends it (last_byte or empty_sample) is accepted: the byte counters close
// into a snapshot, the control-share products are registered, and the
// verdict is picked into a four-entry result queue. The input keeps taking
// a byte every cycle as long as queued plus in-flight verdicts stay below
// four; the input stalls only while the result side holds verdicts back.
// control_percent may be rewritten only while no sample is in progress and
// no verdict is still being computed.
// ----------------------------------------------------------------------------
`include "text_binary_sniffer_macros.svh"

module text_binary_sniffer
  import tbs_pkg::*;
#(
  parameter longint unsigned MAX_SAMPLE_BYTES = 65535
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [PCT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             in_empty_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_looks_text,
  output logic             out_utf8_clean,
  output logic [2:0]       out_verdict_reason
);

  localparam int CNT_W = $clog2(MAX_SAMPLE_BYTES + 64'd1);

  logic [PCT_W-1:0] pct_r;
  logic             take;
  logic             snap_valid;
  logic [CNT_W-1:0] snap_bytes, snap_c0, snap_c1;
  snap_flags_t      snap_flags;
  logic             res_valid;
  result_t          res;
  logic             pop;
  result_t          head;
  logic [OCC_W-1:0] fifo_cnt;
  logic [OCC_W:0]   occ;
  logic             text_reason;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else if (cfg_we) begin
      pct_r <= cfg_wdata;
    end
  end

  // queued plus in-flight verdicts
  assign occ      = (OCC_W+1)'(fifo_cnt) + (OCC_W+1)'(snap_valid) + (OCC_W+1)'(res_valid);
  assign in_ready = (occ < (OCC_W+1)'(FIFO_DEPTH));
  assign take     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  tbs_accum #(
    .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES),
    .CNT_W            (CNT_W)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .empty_sample (in_empty_sample),
    .snap_valid   (snap_valid),
    .snap_bytes   (snap_bytes),
    .snap_c0      (snap_c0),
    .snap_c1      (snap_c1),
    .snap_flags   (snap_flags)
  );

  tbs_verdict #(
    .CNT_W (CNT_W)
  ) u_verdict (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_valid  (snap_valid),
    .snap_bytes  (snap_bytes),
    .snap_c0     (snap_c0),
    .snap_c1     (snap_c1),
    .snap_flags  (snap_flags),
    .control_pct (pct_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  tbs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_looks_text     = head.looks_text;
  assign out_utf8_clean     = head.utf8_clean;
  assign out_verdict_reason = head.reason;

  // reasons that go with a text verdict
  assign text_reason = out_verdict_reason inside {REASON_EMPTY, REASON_MARK,
                                                  REASON_UTF8, REASON_LATIN1};

  `TBS_ASSERT_NXT(a_end_snaps, take && (in_last_byte || in_empty_sample), snap_valid)
  `TBS_ASSERT_IMP(a_no_overflow, fifo_cnt == OCC_W'(FIFO_DEPTH), !res_valid || pop)
  `TBS_ASSERT_IMP(a_text_vs_reason, out_valid, out_looks_text == text_reason)
  `TBS_ASSERT_IMP(a_utf8_reason_clean, out_valid && out_verdict_reason == REASON_UTF8, out_utf8_clean)

endmodule

/* dv/text_binary_sniffer_tb.sv */
// ----------------------------------------------------------------------------
// text_binary_sniffer_tb
// self-checking testbench for the text/binary sniffer
// ----------------------------------------------------------------------------
// Streams byte samples into the sniffer and predicts each verdict from a
// cycle-free model of the counters, the byte order mark check and the strict
// utf-8 decoder. Directed samples cover empty samples, marks, NUL, control
// shares and utf-8 boundary bytes. Half the random samples are well-formed
// utf-8 with controls mixed in; the rest are latin-1, broken, marked, noise
// and empty samples, over several control_percent settings and idling patterns.
// ----------------------------------------------------------------------------
module text_binary_sniffer_tb;
  import tbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAT_MAX     = 65535;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    RANGE_80_BF,
    RANGE_A0_BF,
    RANGE_80_9F,
    RANGE_90_BF,
    RANGE_80_8F
  } cont_range_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [PCT_W-1:0] cfg_wdata = PCT_RESET;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_last_byte = 1'b0;
  logic             in_empty_sample = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_looks_text;
  logic             out_utf8_clean;
  logic [2:0]       out_verdict_reason;

  // sniffer model state
  logic [PCT_W-1:0] ctl_pct = PCT_RESET;
  logic [23:0]      lead_bytes = '0;
  int unsigned      byte_cnt = 0;
  int unsigned      c0_cnt = 0;
  int unsigned      c1_cnt = 0;
  bit               nul_seen = 1'b0;
  int unsigned      cont_owed = 0;
  cont_range_t      next_range = RANGE_80_BF;
  bit               utf8_broken = 1'b0;

  result_t          verdict_q[$];
  logic [7:0]       sample_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int verdicts_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  text_binary_sniffer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .in_empty_sample    (in_empty_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_looks_text     (out_looks_text),
    .out_utf8_clean     (out_utf8_clean),
    .out_verdict_reason (out_verdict_reason)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit too_many(int unsigned count);
    return longint'(count) * 100 > longint'(byte_cnt) * longint'(ctl_pct);
  endfunction

  function automatic void judge_request(logic [7:0] b, logic last, logic empty);
    result_t     v;
    logic [7:0]  lo;
    logic [7:0]  hi;
    if (!empty) begin
      if (byte_cnt < 3) lead_bytes[8*byte_cnt +: 8] = b;
      if (byte_cnt < SAT_MAX) byte_cnt++;
      if (b == 8'h00) begin
        nul_seen = 1'b1;
      end else if (b < 8'h20 && b != 8'h09 && b != 8'h0A && b != 8'h0C && b != 8'h0D) begin
        if (c0_cnt < SAT_MAX) c0_cnt++;
      end else if (b >= 8'h80 && b <= 8'h9F) begin
        if (c1_cnt < SAT_MAX) c1_cnt++;
      end
      if (!utf8_broken) begin
        if (cont_owed != 0) begin
          lo = 8'h80;
          hi = 8'hBF;
          case (next_range)
            RANGE_A0_BF: lo = 8'hA0;
            RANGE_80_9F: hi = 8'h9F;
            RANGE_90_BF: lo = 8'h90;
            RANGE_80_8F: hi = 8'h8F;
            default: ;
          endcase
          if (b < lo || b > hi) begin
            utf8_broken = 1'b1;
          end else begin
            cont_owed--;
            next_range = RANGE_80_BF;
          end
        end else begin
          next_range = RANGE_80_BF;
          if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_owed = 1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cont_owed = 2;
            if (b == 8'hE0) next_range = RANGE_A0_BF;
            else if (b == 8'hED) next_range = RANGE_80_9F;
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cont_owed = 3;
            if (b == 8'hF0) next_range = RANGE_90_BF;
            else if (b == 8'hF4) next_range = RANGE_80_8F;
          end else if (b >= 8'h80) begin
            utf8_broken = 1'b1;
          end
        end
      end
    end
    if (last || empty) begin
      v.utf8_clean = !utf8_broken;
      if (byte_cnt == 0) begin
        v.looks_text = 1'b1;
        v.reason = REASON_EMPTY;
      end else if ((byte_cnt >= 3 && lead_bytes == 24'hBFBBEF) ||
                   (byte_cnt >= 2 && (lead_bytes[15:0] == 16'hFEFF ||
                                      lead_bytes[15:0] == 16'hFFFE))) begin
        v.looks_text = 1'b1;
        v.reason = REASON_MARK;
      end else if (nul_seen) begin
        v.looks_text = 1'b0;
        v.reason = REASON_NUL;
      end else if (too_many(c0_cnt)) begin
        v.looks_text = 1'b0;
        v.reason = REASON_C0;
      end else if (!utf8_broken) begin
        v.looks_text = 1'b1;
        v.reason = REASON_UTF8;
      end else if (too_many(c1_cnt)) begin
        v.looks_text = 1'b0;
        v.reason = REASON_C1;
      end else begin
        v.looks_text = 1'b1;
        v.reason = REASON_LATIN1;
      end
      verdict_q.push_back(v);
      lead_bytes = '0;
      byte_cnt = 0;
      c0_cnt = 0;
      c1_cnt = 0;
      nul_seen = 1'b0;
      cont_owed = 0;
      next_range = RANGE_80_BF;
      utf8_broken = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("verdict %0d: %s", verdicts_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_verdict
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none pending");
      end else begin
        want = verdict_q.pop_front();
        if (out_looks_text !== want.looks_text)
          report_mismatch($sformatf("looks_text got %0d want %0d",
                                    out_looks_text, want.looks_text));
        if (out_utf8_clean !== want.utf8_clean)
          report_mismatch($sformatf("utf8_clean got %0d want %0d",
                                    out_utf8_clean, want.utf8_clean));
        if (out_verdict_reason !== want.reason)
          report_mismatch($sformatf("verdict_reason got %0d want %0d",
                                    out_verdict_reason, want.reason));
      end
      verdicts_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("text_binary_sniffer: mismatch");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic last, input logic empty);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_last_byte    <= last;
    in_empty_sample <= empty;
    do @(posedge clk); while (in_ready !== 1'b1);
    judge_request(b, last, empty);
    items_sent++;
  endtask

  // bytes of sample_bytes, closed by last_byte or by an empty marker
  task automatic send_sample(input bit marker_end);
    int n;
    n = sample_bytes.size();
    if (n == 0) marker_end = 1'b1;
    for (int i = 0; i < n; i++)
      send_request(sample_bytes[i], !marker_end && i == n - 1, 1'b0);
    if (marker_end)
      send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    sample_bytes.delete();
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_percent(input logic [PCT_W-1:0] pct);
    drain_verdicts();
    cfg_we    <= 1'b1;
    cfg_wdata <= pct;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ctl_pct = pct;
  endtask

  function automatic logic [7:0] pick_in(int lo, int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 8'(lo);
    if (r == 1) return 8'(hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void add_char(int ctl_chance);
    int          kind;
    logic [7:0]  lead;
    int          lo;
    int          hi;
    kind = $urandom_range(0, 99);
    lo = 8'h80;
    hi = 8'hBF;
    if (kind < ctl_chance) begin
      sample_bytes.push_back(pick_in(8'h01, 8'h1F));
    end else if (kind < 60) begin
      sample_bytes.push_back(pick_in(8'h20, 8'h7E));
    end else if (kind < 68) begin
      sample_bytes.push_back(pick_in(8'h01, 8'h7F));
    end else if (kind < 80) begin
      sample_bytes.push_back(pick_in(8'hC2, 8'hDF));
      sample_bytes.push_back(pick_in(8'h80, 8'hBF));
    end else if (kind < 92) begin
      lead = pick_in(8'hE0, 8'hEF);
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
      sample_bytes.push_back(lead);
      sample_bytes.push_back(pick_in(lo, hi));
      sample_bytes.push_back(pick_in(8'h80, 8'hBF));
    end else begin
      lead = pick_in(8'hF0, 8'hF4);
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
      sample_bytes.push_back(lead);
      sample_bytes.push_back(pick_in(lo, hi));
      sample_bytes.push_back(pick_in(8'h80, 8'hBF));
      sample_bytes.push_back(pick_in(8'h80, 8'hBF));
    end
  endfunction

  task automatic send_random_sample();
    int kind;
    int n;
    int pos;
    int ctl;
    kind = $urandom_range(0, 99);
    n = $urandom_range(1, 10);
    case ($urandom_range(0, 3))
      0: ctl = 0;
      1: ctl = 3;
      2: ctl = 15;
      default: ctl = 40;
    endcase
    if (kind < 50) begin
      repeat (n) add_char(ctl);
    end else if (kind < 62) begin
      repeat (n)
        sample_bytes.push_back($urandom_range(0, 2) == 0 ? pick_in(8'h80, 8'h9F)
                                                         : pick_in(8'h20, 8'hFF));
    end else if (kind < 74) begin
      repeat (n) add_char(ctl);
      pos = $urandom_range(0, sample_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: sample_bytes[pos] = 8'($urandom_range(0, 255));
        1: sample_bytes.insert(pos, pick_in(8'h80, 8'hBF));
        default: while (sample_bytes.size() > pos + 1) void'(sample_bytes.pop_back());
      endcase
    end else if (kind < 82) begin
      case ($urandom_range(0, 2))
        0: sample_bytes = '{8'hEF, 8'hBB, 8'hBF};
        1: sample_bytes = '{8'hFF, 8'hFE};
        default: sample_bytes = '{8'hFE, 8'hFF};
      endcase
      if ($urandom_range(0, 3) == 0) void'(sample_bytes.pop_back());
      repeat ($urandom_range(0, 6)) sample_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 8)) sample_bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_sample($urandom_range(0, 4) == 0);
  endtask

  task automatic test_empty_samples();
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    sample_bytes = '{8'h41};
    send_sample(1'b1);
  endtask

  task automatic test_byte_order_marks();
    sample_bytes = '{8'hEF, 8'hBB, 8'hBF};
    send_sample(1'b0);
    sample_bytes = '{8'hFE, 8'hFF};
    send_sample(1'b0);
    // mark wins over a later NUL
    sample_bytes = '{8'hFF, 8'hFE, 8'h00};
    send_sample(1'b0);
    // too short for the utf-8 mark
    sample_bytes = '{8'hEF, 8'hBB};
    send_sample(1'b0);
  endtask

  task automatic test_nul_and_controls();
    sample_bytes = '{8'h00};
    send_sample(1'b0);
    sample_bytes = '{8'h41, 8'h01};
    send_sample(1'b0);
    sample_bytes = '{8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h7F};
    send_sample(1'b0);
  endtask

  task automatic test_utf8_rules();
    sample_bytes = '{8'hE0, 8'hA0};
    send_sample(1'b0);
    sample_bytes = '{8'hED, 8'hA0};
    send_sample(1'b0);
    sample_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_sample(1'b0);
    sample_bytes = '{8'h80};
    send_sample(1'b0);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [PCT_W-1:0] pct_a,
                                   input logic [PCT_W-1:0] pct_b, input int items);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_percent(pct_a);
    start = items_sent;
    while (items_sent - start < items / 2) send_random_sample();
    set_percent(pct_b);
    start = items_sent;
    while (items_sent - start < items / 2) send_random_sample();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 49;
    test_empty_samples();
    test_byte_order_marks();
    test_nul_and_controls();
    test_utf8_rules();
    test_random_phase(28, 49, 7'd0, 7'd127, 700);
    test_random_phase(49, 28, 7'd100, 7'($urandom_range(0, 127)), 700);
    test_random_phase(0, 0, 7'($urandom_range(0, 100)), 7'd10, 600);
    drain_verdicts();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("text_binary_sniffer: match");
    end else begin
      $display("text_binary_sniffer: mismatch");
    end
    $finish;
  end

endmodule
